@@ hdl/spss_pkg.sv @@
// ----------------------------------------------------------------------------
// spss_pkg: shared types and constants of the sorted pair sum search unit
// Capacity of the value store, derived index widths, and the packed payload,
// store write and search job types passed between the front and back parts.
// ----------------------------------------------------------------------------
package spss_pkg;

	// store capacity and the widths that follow from it
	localparam int CAPACITY = 128;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int SUM_W    = VALUE_W + 1;

	// one input beat
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_last;
	} in_t;

	// one result beat
	typedef struct packed {
		logic                      found;
		logic signed [VALUE_W-1:0] smaller_value;
		logic signed [VALUE_W-1:0] larger_value;
		logic                      overflowed;
		logic                      last_result;
	} out_t;

	// one write into the value store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [VALUE_W-1:0] data;
	} wr_t;

	// one finished list handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             overflowed;
	} job_t;

endpackage

@@ hdl/spss_ram.sv @@
// ----------------------------------------------------------------------------
// spss_ram: value store
// Generic memory with one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module spss_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read two entries, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ hdl/spss_front.sv @@
// ----------------------------------------------------------------------------
// spss_front: list loader
// Accepts input beats, writes values into the store while there is room,
// flags dropped values, and hands the finished list to the back part.
// ----------------------------------------------------------------------------
module spss_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  spss_pkg::in_t      item,
	output spss_pkg::wr_t      wr,
	output logic               push,
	output spss_pkg::job_t     job
);

	logic [spss_pkg::CNT_W-1:0] count_q;
	logic                       ovf_q;
	logic                       accept;
	logic                       room;
	logic [spss_pkg::CNT_W-1:0] count_next;
	logic                       ovf_next;

	assign accept = start & ~busy;
	assign room   = count_q < spss_pkg::CNT_W'(spss_pkg::CAPACITY);

	// store the value while there is room, otherwise drop it
	always_comb begin
		wr.en      = accept & room;
		wr.addr    = count_q[spss_pkg::ADDR_W-1:0];
		wr.data    = item.value;
		count_next = room ? count_q + spss_pkg::CNT_W'(1) : count_q;
		ovf_next   = ovf_q | ~room;
	end

	// hand the list over on its last beat
	assign push           = accept & item.is_last;
	assign job.count      = count_next;
	assign job.overflowed = ovf_next;

	// advance the fill count, clear it for the next list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (item.is_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_next;
				ovf_q   <= ovf_next;
			end
		end
	end

	a_push_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0) && !ovf_q)
		else $error("fill count not cleared after list handover");

endmodule

@@ hdl/spss_queue.sv @@
// ----------------------------------------------------------------------------
// spss_queue: job queue
// Two-entry queue of finished lists between the loader and the search walk.
// ----------------------------------------------------------------------------
module spss_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spss_pkg::job_t push_job,
	input  logic           pop,
	output logic           empty,
	output spss_pkg::job_t head
);

	spss_pkg::job_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           do_push;
	logic           do_pop;

	assign empty   = (fill_q == 2'd0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push & (fill_q != 2'd2);
	assign do_pop  = pop & ~empty;

	// hold queued jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hdl/spss_back.sv @@
// ----------------------------------------------------------------------------
// spss_back: two-pointer search walk
// Takes a list from the queue and walks it from both ends, a store read then a
// compare per step; a match is held one step so the final result can be marked.
// ----------------------------------------------------------------------------
module spss_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic signed [spss_pkg::SUM_W-1:0]  cfg_data,
	input  logic                               q_empty,
	input  spss_pkg::job_t                     q_head,
	output logic                               pop,
	output logic                               active,
	output logic [spss_pkg::ADDR_W-1:0]        raddr_a,
	output logic [spss_pkg::ADDR_W-1:0]        raddr_b,
	input  logic [spss_pkg::VALUE_W-1:0]       rdata_a,
	input  logic [spss_pkg::VALUE_W-1:0]       rdata_b,
	output logic                               result_strobe,
	output spss_pkg::out_t                     result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_COMP,
		S_FIN
	} state_t;

	state_t                              state_q;
	logic signed [spss_pkg::SUM_W-1:0]   target_q;
	logic [spss_pkg::ADDR_W-1:0]         left_q;
	logic [spss_pkg::ADDR_W-1:0]         right_q;
	logic                                ovf_q;
	logic                                pend_valid_q;
	logic [spss_pkg::VALUE_W-1:0]        pend_small_q;
	logic [spss_pkg::VALUE_W-1:0]        pend_large_q;
	logic                                strobe_q;
	spss_pkg::out_t                      res_q;

	logic signed [spss_pkg::SUM_W-1:0]   sum;
	logic                                hit;
	logic                                below;
	logic [spss_pkg::ADDR_W-1:0]         next_left;
	logic [spss_pkg::ADDR_W-1:0]         next_right;

	assign pop           = (state_q == S_IDLE) & ~q_empty;
	assign active        = (state_q != S_IDLE);
	assign raddr_a       = left_q;
	assign raddr_b       = right_q;
	assign result_strobe = strobe_q;
	assign result        = res_q;

	// form the 33-bit sum and pick the next pointer move
	always_comb begin
		sum        = $signed({rdata_a[spss_pkg::VALUE_W-1], rdata_a})
		           + $signed({rdata_b[spss_pkg::VALUE_W-1], rdata_b});
		hit        = (sum == target_q);
		below      = (sum < target_q);
		next_left  = left_q;
		next_right = right_q;
		if (hit) begin
			next_left  = left_q + spss_pkg::ADDR_W'(1);
			next_right = right_q - spss_pkg::ADDR_W'(1);
		end else if (below) begin
			next_left  = left_q + spss_pkg::ADDR_W'(1);
		end else begin
			next_right = right_q - spss_pkg::ADDR_W'(1);
		end
	end

	// walk sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			target_q     <= '0;
			left_q       <= '0;
			right_q      <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_small_q <= '0;
			pend_large_q <= '0;
			strobe_q     <= 1'b0;
			res_q        <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				target_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						left_q       <= '0;
						right_q      <= spss_pkg::ADDR_W'(q_head.count
						                - spss_pkg::CNT_W'(1));
						ovf_q        <= q_head.overflowed;
						pend_valid_q <= 1'b0;
						state_q      <= (q_head.count < spss_pkg::CNT_W'(2)) ? S_FIN
						                                                     : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_COMP;
				end
				S_COMP: begin
					// release the held match, hold the new one
					if (hit) begin
						if (pend_valid_q) begin
							strobe_q            <= 1'b1;
							res_q.found         <= 1'b1;
							res_q.smaller_value <= pend_small_q;
							res_q.larger_value  <= pend_large_q;
							res_q.overflowed    <= ovf_q;
							res_q.last_result   <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_small_q <= rdata_a;
						pend_large_q <= rdata_b;
					end
					left_q  <= next_left;
					right_q <= next_right;
					state_q <= (next_left < next_right) ? S_READ : S_FIN;
				end
				S_FIN: begin
					// final beat: the held match, or the not-found beat
					strobe_q            <= 1'b1;
					res_q.found         <= pend_valid_q;
					res_q.smaller_value <= pend_valid_q ? pend_small_q : '0;
					res_q.larger_value  <= pend_valid_q ? pend_large_q : '0;
					res_q.overflowed    <= ovf_q;
					res_q.last_result   <= 1'b1;
					pend_valid_q        <= 1'b0;
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_read_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (left_q < right_q))
		else $error("walk read with crossed pointers");

	a_fin_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (strobe_q && res_q.last_result && (state_q == S_IDLE)))
		else $error("search end without final result beat");

	a_notfound_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !res_q.found) |-> res_q.last_result)
		else $error("not-found beat not marked final");

	a_pop_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == S_READ) || (state_q == S_FIN))
		else $error("job taken without starting a walk");

endmodule

@@ hdl/sorted_pair_sum_search_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_pair_sum_search_unit: pairs of an ascending list that hit a target
// Loads a list of signed values, then emits every pair that adds up to the
// configured target sum, found by a two-pointer walk over the stored list.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; a beat is taken at each edge with
//   start high and busy low. Values load one per cycle while busy is low into
//   a store of CAPACITY entries; values beyond it are dropped and reported
//   through the overflowed field. The beat with is_last set closes the list.
//   Search: after the last beat busy stays high for the walk. Each pointer
//   step is a store read, then a 33-bit add and compare, with at most N-1
//   steps for N stored values; busy falls with the final result.
//   Results: each beat shows on result for one cycle with result_strobe
//   high, matches in order of rising smaller value, the last one marked by
//   last_result; with no match a single beat with found low is sent.
//   The receiver cannot stall: every strobed beat is taken.
//   Configuration: cfg_data (target sum) is to be written with cfg_valid
//   while idle; the block does not enforce this. cfg_ready is always high.
//   Reset clears the fill count, the overflow flag and the target; the
//   store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_pair_sum_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  spss_pkg::in_t                     item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic signed [spss_pkg::SUM_W-1:0] cfg_data,
	output logic                              result_strobe,
	output spss_pkg::out_t                    result
);

	spss_pkg::wr_t                  wr;
	logic                           push;
	spss_pkg::job_t                 push_job;
	logic                           pop;
	logic                           q_empty;
	spss_pkg::job_t                 q_head;
	logic                           back_active;
	logic [spss_pkg::ADDR_W-1:0]    raddr_a;
	logic [spss_pkg::ADDR_W-1:0]    raddr_b;
	logic [spss_pkg::VALUE_W-1:0]   rdata_a;
	logic [spss_pkg::VALUE_W-1:0]   rdata_b;

	// hold input off while a list waits or is being searched
	assign busy      = ~q_empty | back_active;
	assign cfg_ready = 1'b1;

	spss_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.wr     (wr),
		.push   (push),
		.job    (push_job)
	);

	spss_ram #(
		.DEPTH (spss_pkg::CAPACITY),
		.WIDTH (spss_pkg::VALUE_W)
	) u_ram (
		.clk     (clk),
		.we      (wr.en),
		.waddr   (wr.addr),
		.wdata   (wr.data),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	spss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	spss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.active        (back_active),
		.raddr_a       (raddr_a),
		.raddr_b       (raddr_b),
		.rdata_a       (rdata_a),
		.rdata_b       (rdata_b),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

@@ tb/pair_sum_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_sum_checker: predicts and checks the pair sum search results
// Watches the item, configuration and result channels of the unit, keeps its
// own copy of the loaded list and the target sum, runs the two-pointer walk
// when a list closes and compares every result beat field by field.
// ----------------------------------------------------------------------------
module pair_sum_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  spss_pkg::in_t                     item,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic signed [spss_pkg::SUM_W-1:0] cfg_data,
	input  logic                              result_strobe,
	input  spss_pkg::out_t                    result,
	output int                                mismatch_count,
	output int                                results_owed
);

	logic signed [spss_pkg::VALUE_W-1:0] list_mem [spss_pkg::CAPACITY];
	int                                  fill_level;
	logic                                dropped;
	logic signed [spss_pkg::SUM_W-1:0]   target_sum;
	spss_pkg::out_t                      owed_pairs [$];

	// store one value; on the closing beat walk the list and queue its pairs
	task automatic walk_list(input spss_pkg::in_t beat);
		spss_pkg::out_t batch [$];
		spss_pkg::out_t r;
		int             lo;
		int             hi;
		longint         total;
		if (fill_level < spss_pkg::CAPACITY) begin
			list_mem[fill_level] = beat.value;
			fill_level++;
		end else begin
			dropped = 1'b1;
		end
		if (!beat.is_last)
			return;
		lo = 0;
		hi = fill_level - 1;
		while (lo < hi) begin
			total = longint'(list_mem[lo]) + longint'(list_mem[hi]);
			if (total == longint'(target_sum)) begin
				r = spss_pkg::out_t'{found: 1'b1, smaller_value: list_mem[lo],
					larger_value: list_mem[hi], overflowed: dropped, last_result: 1'b0};
				batch = {batch, r};
				lo++;
				hi--;
			end else if (total < longint'(target_sum)) begin
				lo++;
			end else begin
				hi--;
			end
		end
		// no match at all: one not-found beat
		if (batch.size() == 0) begin
			r = spss_pkg::out_t'{found: 1'b0, smaller_value: '0, larger_value: '0,
				overflowed: dropped, last_result: 1'b0};
			batch = {batch, r};
		end
		batch[batch.size() - 1].last_result = 1'b1;
		owed_pairs = {owed_pairs, batch};
		fill_level = 0;
		dropped    = 1'b0;
	endtask

	// compare one result beat with the oldest owed one
	task automatic compare_beat(input spss_pkg::out_t got);
		spss_pkg::out_t want;
		if (owed_pairs.size() == 0) begin
			$error("result beat with nothing owed: found %0d smaller %0d larger %0d",
				got.found, got.smaller_value, got.larger_value);
			mismatch_count++;
			return;
		end
		want = owed_pairs.pop_front();
		if (got.found !== want.found) begin
			$error("found: expected %0d, actual %0d", want.found, got.found);
			mismatch_count++;
		end
		if (got.smaller_value !== want.smaller_value) begin
			$error("smaller_value: expected %0d, actual %0d",
				want.smaller_value, got.smaller_value);
			mismatch_count++;
		end
		if (got.larger_value !== want.larger_value) begin
			$error("larger_value: expected %0d, actual %0d",
				want.larger_value, got.larger_value);
			mismatch_count++;
		end
		if (got.overflowed !== want.overflowed) begin
			$error("overflowed: expected %0d, actual %0d", want.overflowed, got.overflowed);
			mismatch_count++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0d, actual %0d", want.last_result, got.last_result);
			mismatch_count++;
		end
	endtask

	// sample every channel at the edge that accepts its beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_level = 0;
			dropped    = 1'b0;
			target_sum = '0;
			owed_pairs.delete();
			results_owed <= 0;
		end else begin
			if (result_strobe)
				compare_beat(result);
			if (cfg_valid && cfg_ready)
				target_sum = cfg_data;
			if (start && !busy)
				walk_list(item);
			results_owed <= owed_pairs.size();
		end
	end

endmodule

@@ tb/sorted_pair_sum_search_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pair_sum_search_unit_tb: stimulus and verdict for the pair search
// Loads directed lists that hit the value and target extremes, then random
// ascending lists built around each target so pairs are common, with some
// unsorted and one overflowing list, under random gaps between beats.
// ----------------------------------------------------------------------------
module sorted_pair_sum_search_unit_tb;

	localparam int     GAP_MAX      = 4;
	localparam int     DRAIN_CYCLES = 2 * spss_pkg::CAPACITY + 8;
	localparam int     STALL_LIMIT  = 4000;
	localparam int     RANDOM_ITEMS = 320;
	localparam int     PHASES       = 8;
	localparam longint VAL_MIN      = -(64'sd1 <<< 31);
	localparam longint VAL_MAX      = (64'sd1 <<< 31) - 1;
	localparam longint TGT_MIN      = -(64'sd1 <<< 32);
	localparam longint TGT_MAX      = (64'sd1 <<< 32) - 2;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              start     = 1'b0;
	spss_pkg::in_t                     item      = '0;
	logic                              cfg_valid = 1'b0;
	logic signed [spss_pkg::SUM_W-1:0] cfg_data  = '0;
	logic                              busy;
	logic                              cfg_ready;
	logic                              result_strobe;
	spss_pkg::out_t                    result;
	int                                mismatch_count;
	int                                results_owed;
	int                                stall_cycles = 0;
	int                                list_vals [$];

	sorted_pair_sum_search_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.result        (result)
	);

	pair_sum_checker u_pair_sum_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_strobe  (result_strobe),
		.result         (result),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// end the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[sorted_pair_sum_search_unit] ERROR");
			$finish;
		end
	end

	// offer one value after a random gap and hold it until taken
	task automatic push_value(input logic signed [spss_pkg::VALUE_W-1:0] v,
			input logic last, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= spss_pkg::in_t'{value: v, is_last: last};
		do @(posedge clk); while (busy);
	endtask

	task automatic send_list(input bit no_gap);
		foreach (list_vals[i])
			push_value(list_vals[i], i == list_vals.size() - 1, no_gap);
	endtask

	// hold input off until every owed result is back and the walk has settled
	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (results_owed != 0 || busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_target(input logic signed [spss_pkg::SUM_W-1:0] t);
		cfg_valid <= 1'b1;
		cfg_data  <= t;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// build a list mixing near, wide and boundary values with their complements
	task automatic fill_list(input longint tgt, input int len, input bit scrambled);
		longint x;
		longint y;
		list_vals.delete();
		while (list_vals.size() < len) begin
			case ($urandom_range(0, 3))
				0: x = longint'($urandom_range(0, 64)) - 32;
				1: x = longint'(int'($urandom()));
				2: begin
					case ($urandom_range(0, 6))
						0: x = VAL_MIN;
						1: x = VAL_MIN + 1;
						2: x = -1;
						3: x = 0;
						4: x = 1;
						5: x = VAL_MAX - 1;
						default: x = VAL_MAX;
					endcase
				end
				default: begin
					x = tgt / 2 + longint'($urandom_range(0, 16)) - 8;
					if (x < VAL_MIN) x = VAL_MIN;
					if (x > VAL_MAX) x = VAL_MAX;
				end
			endcase
			list_vals = {list_vals, int'(x)};
			y = tgt - x;
			if (list_vals.size() < len && y >= VAL_MIN && y <= VAL_MAX && $urandom_range(0, 1))
				list_vals = {list_vals, int'(y)};
		end
		if (!scrambled)
			list_vals.sort();
	endtask

	initial begin
		longint                            tgt;
		logic signed [spss_pkg::SUM_W-1:0] rand_sum;
		int                                phase_items;
		int                                len;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lists under the reset target of zero
		list_vals = '{int'(VAL_MIN), -1, 0, 1, int'(VAL_MAX)};
		send_list(1'b0);
		list_vals = '{0};
		send_list(1'b0);
		list_vals = '{9, -9, 4, -4};
		send_list(1'b1);

		// several pairs in one walk
		wait_quiet();
		set_target(10);
		list_vals = '{1, 2, 3, 7, 8, 9};
		send_list(1'b0);

		// target extremes
		wait_quiet();
		set_target(spss_pkg::SUM_W'(TGT_MIN));
		list_vals = '{int'(VAL_MIN), int'(VAL_MIN)};
		send_list(1'b0);
		wait_quiet();
		set_target(spss_pkg::SUM_W'(TGT_MAX));
		list_vals = '{int'(VAL_MAX), int'(VAL_MAX)};
		send_list(1'b1);
		list_vals = '{0, 1};
		send_list(1'b0);
		list_vals = '{int'(VAL_MAX)};
		send_list(1'b0);

		// random lists, one target per phase
		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			case (p)
				0: tgt = 0;
				1: tgt = TGT_MIN;
				2: tgt = TGT_MAX;
				3, 5: tgt = longint'($urandom_range(0, 200)) - 100;
				default: begin
					rand_sum = {1'($urandom_range(0, 1)), $urandom()};
					tgt = longint'(rand_sum);
					if (tgt > TGT_MAX) tgt = TGT_MAX;
				end
			endcase
			set_target(spss_pkg::SUM_W'(tgt));
			// overflow the store, dropping the closing value too
			if (p == 4) begin
				fill_list(tgt, spss_pkg::CAPACITY + 3, 1'b0);
				send_list(1'b0);
			end
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / PHASES) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
				fill_list(tgt, len, $urandom_range(0, 6) == 0);
				send_list($urandom_range(0, 3) == 0);
				phase_items += len;
			end
		end

		wait_quiet();
		if (mismatch_count == 0 && results_owed == 0)
			$display("[sorted_pair_sum_search_unit] OK");
		else
			$display("[sorted_pair_sum_search_unit] ERROR");
		$finish;
	end

endmodule
